[rtl/core/tlssni_pkg.sv]
// Shared types and constants for the TLS ClientHello server-name parser.
// Used by tlssni_parse and tls_client_hello_sni_parser; depends on nothing.

package tlssni_pkg;

  typedef enum logic [3:0] {
    PH_RECORD   = 4'd0,
    PH_SID_SKIP = 4'd1,
    PH_CS_LEN   = 4'd2,
    PH_CS_SKIP  = 4'd3,
    PH_CM_LEN   = 4'd4,
    PH_CM_SKIP  = 4'd5,
    PH_EXT_LEN  = 4'd6,
    PH_EXT_HDR  = 4'd7,
    PH_EXT_SKIP = 4'd8,
    PH_SNI_HDR  = 4'd9,
    PH_NAME     = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    REASON_FOUND            = 3'd0,
    REASON_NOT_HANDSHAKE    = 3'd1,
    REASON_NOT_CLIENT_HELLO = 3'd2,
    REASON_SHORT_SNI        = 3'd3,
    REASON_NOT_FOUND        = 3'd4
  } reason_t;

  typedef struct packed {
    logic       name_valid;
    logic [7:0] name_byte;
    logic       verdict_valid;
    reason_t    reason;
  } result_t;

  localparam logic [7:0]  RECORD_TYPE_HANDSHAKE = 8'h16;
  localparam logic [7:0]  HANDSHAKE_CLIENT_HELLO = 8'h01;
  localparam logic [15:0] EXT_TYPE_SERVER_NAME = 16'h0000;

  localparam int unsigned POS_RECORD_TYPE = 0;
  localparam int unsigned POS_HANDSHAKE_TYPE = 5;
  localparam int unsigned POS_SESSION_ID_LEN = 43;
  localparam int unsigned LEN_RECORD_HEADER = 4;
  localparam int unsigned LEN_HELLO_HEADER = 8;

  localparam logic [2:0] HDR_IDX_TYPE_DONE = 3'd2;
  localparam logic [2:0] HDR_IDX_EXT_DONE = 3'd4;
  localparam logic [2:0] HDR_IDX_SNI_DONE = 3'd5;
  localparam int unsigned EXT_HDR_TAIL = 4;
  localparam int unsigned SNI_HDR_LEN = 5;

endpackage

[rtl/core/tlssni_parse.sv]
// Per-byte parse state and next-state logic for the server-name parser.
// Depends on tlssni_pkg; the state advances on each enabled byte.

module tlssni_parse #(
  parameter int unsigned POSITION_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [7:0]          data_byte,
  input  logic                packet_last,
  output tlssni_pkg::result_t result,
  output logic                has_result
);

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned WB = POSITION_BITS + 1;
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

  tlssni_pkg::phase_t phase, phase_next;
  logic [PB-1:0] position, position_next;
  logic [15:0]   skip_remaining, skip_remaining_next;
  logic [15:0]   field_accumulator, field_accumulator_next;
  logic [PB-1:0] extensions_end, extensions_end_next;
  logic [PB-1:0] current_extension_end, current_extension_end_next;
  logic [15:0]   name_remaining, name_remaining_next;
  logic          verdict_given, verdict_given_next;
  logic [2:0]    header_index, header_index_next;
  logic          ext_is_name, ext_is_name_next;

  logic [WB-1:0] p_ext;
  logic [WB-1:0] p_plus1;
  logic [15:0]   acc_new;
  logic [2:0]    hidx_inc;
  logic [WB-1:0] sum_acc;
  logic [PB-1:0] sat_acc;
  logic [WB-1:0] ext_end_ext;
  logic [WB-1:0] cur_end_ext;
  logic [15:0]   skip_dec;
  logic [15:0]   name_dec;
  logic          nv, vv;
  tlssni_pkg::reason_t rs;

  always_comb begin
    p_ext       = {1'b0, position};
    p_plus1     = p_ext + WB'(1);
    acc_new     = {field_accumulator[7:0], data_byte};
    hidx_inc    = header_index + 3'd1;
    sum_acc     = p_plus1 + WB'(acc_new);
    sat_acc     = sum_acc[PB] ? POS_MAX : sum_acc[PB-1:0];
    ext_end_ext = {1'b0, extensions_end};
    skip_dec    = skip_remaining - 16'((skip_remaining != 16'd0) ? 1 : 0);
    name_dec    = name_remaining - 16'((name_remaining != 16'd0) ? 1 : 0);
  end

  always_comb begin
    phase_next                 = phase;
    position_next              = position;
    skip_remaining_next        = skip_remaining;
    field_accumulator_next     = field_accumulator;
    extensions_end_next        = extensions_end;
    current_extension_end_next = current_extension_end;
    name_remaining_next        = name_remaining;
    verdict_given_next         = verdict_given;
    header_index_next          = header_index;
    ext_is_name_next           = ext_is_name;
    cur_end_ext                = {1'b0, current_extension_end};
    nv = 1'b0;
    vv = 1'b0;
    rs = tlssni_pkg::REASON_FOUND;

    if (!verdict_given) begin
      case (phase)
        tlssni_pkg::PH_RECORD: begin
          if (position == PB'(tlssni_pkg::POS_RECORD_TYPE) &&
              data_byte != tlssni_pkg::RECORD_TYPE_HANDSHAKE) begin
            vv = 1'b1;
            rs = tlssni_pkg::REASON_NOT_HANDSHAKE;
          end else if (position == PB'(tlssni_pkg::POS_HANDSHAKE_TYPE) &&
                       data_byte != tlssni_pkg::HANDSHAKE_CLIENT_HELLO) begin
            vv = 1'b1;
            rs = tlssni_pkg::REASON_NOT_CLIENT_HELLO;
          end else if (position == PB'(tlssni_pkg::POS_SESSION_ID_LEN)) begin
            skip_remaining_next = {8'd0, data_byte};
            phase_next = (data_byte != 8'd0) ? tlssni_pkg::PH_SID_SKIP
                                             : tlssni_pkg::PH_CS_LEN;
            header_index_next = 3'd0;
          end
        end
        tlssni_pkg::PH_SID_SKIP, tlssni_pkg::PH_CS_SKIP, tlssni_pkg::PH_CM_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 16'd0) begin
            if (phase == tlssni_pkg::PH_SID_SKIP) begin
              phase_next = tlssni_pkg::PH_CS_LEN;
            end else if (phase == tlssni_pkg::PH_CS_SKIP) begin
              phase_next = tlssni_pkg::PH_CM_LEN;
            end else begin
              phase_next = tlssni_pkg::PH_EXT_LEN;
            end
            header_index_next = 3'd0;
          end
        end
        tlssni_pkg::PH_CS_LEN: begin
          field_accumulator_next = acc_new;
          header_index_next = hidx_inc;
          if (hidx_inc == tlssni_pkg::HDR_IDX_TYPE_DONE) begin
            skip_remaining_next = acc_new;
            phase_next = (acc_new != 16'd0) ? tlssni_pkg::PH_CS_SKIP
                                            : tlssni_pkg::PH_CM_LEN;
            header_index_next = 3'd0;
          end
        end
        tlssni_pkg::PH_CM_LEN: begin
          skip_remaining_next = {8'd0, data_byte};
          phase_next = (data_byte != 8'd0) ? tlssni_pkg::PH_CM_SKIP
                                           : tlssni_pkg::PH_EXT_LEN;
          header_index_next = 3'd0;
        end
        tlssni_pkg::PH_EXT_LEN: begin
          field_accumulator_next = acc_new;
          header_index_next = hidx_inc;
          if (hidx_inc == tlssni_pkg::HDR_IDX_TYPE_DONE) begin
            extensions_end_next = sat_acc;
            phase_next = tlssni_pkg::PH_EXT_HDR;
            header_index_next = 3'd0;
          end
        end
        tlssni_pkg::PH_EXT_HDR: begin
          if (header_index == 3'd0 &&
              (p_ext + WB'(tlssni_pkg::EXT_HDR_TAIL)) > ext_end_ext) begin
            vv = 1'b1;
            rs = tlssni_pkg::REASON_NOT_FOUND;
          end else begin
            field_accumulator_next = acc_new;
            header_index_next = hidx_inc;
            if (hidx_inc == tlssni_pkg::HDR_IDX_TYPE_DONE) begin
              ext_is_name_next = (acc_new == tlssni_pkg::EXT_TYPE_SERVER_NAME);
            end
            if (hidx_inc == tlssni_pkg::HDR_IDX_EXT_DONE) begin
              current_extension_end_next = sat_acc;
              if (ext_is_name) begin
                if ((p_plus1 + WB'(tlssni_pkg::SNI_HDR_LEN)) > ext_end_ext) begin
                  vv = 1'b1;
                  rs = tlssni_pkg::REASON_SHORT_SNI;
                end else begin
                  phase_next = tlssni_pkg::PH_SNI_HDR;
                  header_index_next = 3'd0;
                end
              end else begin
                phase_next = ({1'b0, sat_acc} <= p_plus1) ? tlssni_pkg::PH_EXT_HDR
                                                          : tlssni_pkg::PH_EXT_SKIP;
                header_index_next = 3'd0;
              end
            end
          end
        end
        tlssni_pkg::PH_EXT_SKIP: begin
          if (p_plus1 >= cur_end_ext) begin
            phase_next = tlssni_pkg::PH_EXT_HDR;
            header_index_next = 3'd0;
          end
        end
        tlssni_pkg::PH_SNI_HDR: begin
          field_accumulator_next = acc_new;
          header_index_next = hidx_inc;
          if (hidx_inc == tlssni_pkg::HDR_IDX_SNI_DONE) begin
            if (sum_acc <= ext_end_ext) begin
              if (acc_new == 16'd0) begin
                vv = 1'b1;
                rs = tlssni_pkg::REASON_FOUND;
              end else begin
                name_remaining_next = acc_new;
                phase_next = tlssni_pkg::PH_NAME;
              end
            end else begin
              phase_next = (cur_end_ext <= p_plus1) ? tlssni_pkg::PH_EXT_HDR
                                                    : tlssni_pkg::PH_EXT_SKIP;
              header_index_next = 3'd0;
            end
          end
        end
        tlssni_pkg::PH_NAME: begin
          nv = 1'b1;
          name_remaining_next = name_dec;
          if (name_dec == 16'd0) begin
            vv = 1'b1;
            rs = tlssni_pkg::REASON_FOUND;
          end
        end
        default: begin
          vv = 1'b1;
          rs = tlssni_pkg::REASON_NOT_FOUND;
        end
      endcase

      if (!vv && packet_last) begin
        vv = 1'b1;
        if (phase_next == tlssni_pkg::PH_RECORD) begin
          if (position < PB'(tlssni_pkg::LEN_RECORD_HEADER)) begin
            rs = tlssni_pkg::REASON_NOT_HANDSHAKE;
          end else if (position < PB'(tlssni_pkg::LEN_HELLO_HEADER)) begin
            rs = tlssni_pkg::REASON_NOT_CLIENT_HELLO;
          end else begin
            rs = tlssni_pkg::REASON_NOT_FOUND;
          end
        end else if (phase_next == tlssni_pkg::PH_SNI_HDR) begin
          rs = tlssni_pkg::REASON_SHORT_SNI;
        end else begin
          rs = tlssni_pkg::REASON_NOT_FOUND;
        end
      end
      if (vv) begin
        verdict_given_next = 1'b1;
      end
    end

    position_next = (position == POS_MAX) ? position : p_plus1[PB-1:0];

    if (packet_last) begin
      phase_next                 = tlssni_pkg::PH_RECORD;
      position_next              = '0;
      skip_remaining_next        = '0;
      field_accumulator_next     = '0;
      extensions_end_next        = '0;
      current_extension_end_next = '0;
      name_remaining_next        = '0;
      verdict_given_next         = 1'b0;
      header_index_next          = '0;
      ext_is_name_next           = 1'b0;
    end

    result.name_valid    = nv;
    result.name_byte     = nv ? data_byte : 8'd0;
    result.verdict_valid = vv;
    result.reason        = vv ? rs : tlssni_pkg::REASON_FOUND;
    has_result           = nv | vv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                 <= tlssni_pkg::PH_RECORD;
      position              <= '0;
      skip_remaining        <= '0;
      field_accumulator     <= '0;
      extensions_end        <= '0;
      current_extension_end <= '0;
      name_remaining        <= '0;
      verdict_given         <= 1'b0;
      header_index          <= '0;
      ext_is_name           <= 1'b0;
    end else if (en) begin
      phase                 <= phase_next;
      position              <= position_next;
      skip_remaining        <= skip_remaining_next;
      field_accumulator     <= field_accumulator_next;
      extensions_end        <= extensions_end_next;
      current_extension_end <= current_extension_end_next;
      name_remaining        <= name_remaining_next;
      verdict_given         <= verdict_given_next;
      header_index          <= header_index_next;
      ext_is_name           <= ext_is_name_next;
    end
  end

endmodule

[rtl/core/tls_client_hello_sni_parser.sv]
// TLS ClientHello server-name parser, top level; uses tlssni_pkg and tlssni_parse.
// A byte is held in the input register, then parsed into the result register.
// Throughput: one byte per cycle while result_stall is low, set by the
// combinational parse step between the input register and the result register.
// Reset: synchronous rst clears both stages and returns the parser to the
// start of a packet.

module tls_client_hello_sni_parser #(
  parameter int unsigned POSITION_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_stall,
  input  logic [7:0]          data_byte,
  input  logic                packet_last,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                name_valid,
  output logic [7:0]          name_byte,
  output logic                verdict_valid,
  output tlssni_pkg::reason_t reason
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  logic       accept;
  logic       step_has_result;
  tlssni_pkg::result_t step_result;

  assign advance    = in_full && (!result_valid || !result_stall);
  assign data_stall = in_full && !advance;
  assign accept     = data_valid && !data_stall;

  tlssni_parse #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .data_byte  (in_byte),
    .packet_last(in_last),
    .result     (step_result),
    .has_result (step_has_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= accept || (in_full && !advance);
    end
    if (accept) begin
      in_byte <= data_byte;
      in_last <= packet_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step_has_result;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance && step_has_result) begin
      name_valid    <= step_result.name_valid;
      name_byte     <= step_result.name_byte;
      verdict_valid <= step_result.verdict_valid;
      reason        <= step_result.reason;
    end
  end

  a_result_has_content: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (name_valid || verdict_valid))
    else $error("result transfer carries neither a name byte nor a verdict");

  a_reason_only_with_verdict: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !verdict_valid) |-> (reason == tlssni_pkg::REASON_FOUND))
    else $error("reason set without a verdict");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> (result_valid && result_stall))
    else $error("input stalled while the result register could take a transfer");

  a_stalled_byte_kept: assert property (@(posedge clk) disable iff (rst)
    data_stall |=> in_full)
    else $error("held input byte lost during a stall");

endmodule
